// File: design/ratio_median_smoother_unit_macros.svh
// assertion helpers for the ratio median smoother
`ifndef RATIO_MEDIAN_SMOOTHER_UNIT_MACROS_SVH
`define RATIO_MEDIAN_SMOOTHER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMS_ASSERT_CLK(lbl, ck, rs, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rs) prop) else $error(msg);
`define RMS_ASSERT(lbl, prop, msg) \
    `RMS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define RMS_ASSERT_CLK(lbl, ck, rs, prop, msg)
`define RMS_ASSERT(lbl, prop, msg)
`endif
`endif

// File: design/rms_pkg.sv
package rms_pkg;

    localparam int MAX_HALF_DEF = 7;
    localparam int LEN_W = 24;
    localparam int RATIO_W = 20;
    localparam int FRAC_BITS = 16;
    localparam int OVF_SH = RATIO_W - FRAC_BITS;
    localparam int HALF_W = 3;
    localparam int QCNT_W = $clog2(RATIO_W + 1);
    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
    localparam logic [HALF_W-1:0] HALF_RESET = 3'd2;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_DIV,
        CTL_PLAN,
        CTL_CHECK,
        CTL_MWAIT,
        CTL_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        MED_IDLE,
        MED_CAND,
        MED_LOAD,
        MED_READ,
        MED_CMP
    } med_state_t;

endpackage

// File: design/ratio_median_smoother_unit.sv
// ratio median smoother
// s_tdata carries measured and computed lengths, s_tlast marks the final
// interval of a run; cfg_data writes half_window (neighbours per side).
// each item is divided measured/computed into a Q4.16 ratio by a bit-serial
// divider (skipped when the ratio saturates) and stored in a 15-entry
// ratio memory.
// a median is found by rank counting over the window: each candidate is
// ranked with one memory read per ratio in the window, and there are at
// most n candidates for a window of n ratios (n up to 15).
// a normal item gives at most one result (that of the item half_window back);
// the final item flushes up to half_window+1 results, m_tlast on the last one.
// s_tready and cfg_ready are high only while idle; one item is in work at a
// time, and a configuration write wins over an input transaction.
// a result waits in the output register while m_tready is low, and the
// block holds until it is taken.
// reset clears the run count and sets half_window to two; no clearing pass.
// a configuration write discards the current run.
`include "ratio_median_smoother_unit_macros.svh"
module ratio_median_smoother_unit
    import rms_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // measured_length, computed_length
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // smoothed_ratio, zero pad
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [HALF_W-1:0]     cfg_data
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ctl_state_t         state_reg, state_next;
    logic [HALF_W-1:0]  half_reg, half_next;
    logic [CW-1:0]      items_reg, items_next;
    logic [AW-1:0]      age_reg, age_next;
    logic               fin_reg, fin_next;
    logic [RATIO_W-1:0] out_reg, out_next;
    logic               last_reg, last_next;

    logic               div_start, div_done;
    logic [RATIO_W-1:0] div_q;
    logic               med_start, med_done;
    logic [RATIO_W-1:0] med_res;
    logic [AW-1:0]      h_eff;
    logic [AW:0]        hi_raw;
    logic [AW:0]        hi_cap;
    logic [AW-1:0]      med_hi;
    logic               age_ok;

    assign h_eff = (int'(half_reg) > MAX_HALF) ? AW'(MAX_HALF) : AW'(half_reg);
    assign hi_raw = {1'b0, age_reg} + {1'b0, h_eff};
    assign hi_cap = (AW+1)'(items_reg) - 1'b1;
    assign med_hi = (hi_raw > hi_cap) ? hi_cap[AW-1:0] : hi_raw[AW-1:0];
    assign age_ok = int'(age_reg) < int'(items_reg);

    assign s_tready = (state_reg == CTL_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == CTL_IDLE);
    assign m_tvalid = (state_reg == CTL_OUT);
    assign m_tdata = OUT_DATA_W'(out_reg);
    assign m_tlast = last_reg;
    assign div_start = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        half_next = half_reg;
        items_next = items_reg;
        age_next = age_reg;
        fin_next = fin_reg;
        out_next = out_reg;
        last_next = last_reg;
        med_start = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (cfg_valid)
                begin
                    half_next = cfg_data;
                    items_next = '0;
                end
                else if (s_tvalid)
                begin
                    fin_next = s_tlast;
                    state_next = CTL_DIV;
                end
            end
            CTL_DIV:
            begin
                if (div_done)
                begin
                    if (items_reg != CW'(DEPTH))
                    begin
                        items_next = items_reg + 1'b1;
                    end
                    state_next = CTL_PLAN;
                end
            end
            CTL_PLAN:
            begin
                age_next = h_eff;
                state_next = CTL_CHECK;
            end
            CTL_CHECK:
            begin
                if (age_ok)
                begin
                    med_start = 1'b1;
                    state_next = CTL_MWAIT;
                end
                else if (fin_reg)
                begin
                    age_next = age_reg - 1'b1;
                end
                else
                begin
                    state_next = CTL_IDLE;
                end
            end
            CTL_MWAIT:
            begin
                if (med_done)
                begin
                    out_next = med_res;
                    last_next = fin_reg && (age_reg == '0);
                    state_next = CTL_OUT;
                end
            end
            CTL_OUT:
            begin
                if (m_tready)
                begin
                    if (fin_reg && (age_reg != '0))
                    begin
                        age_next = age_reg - 1'b1;
                        state_next = CTL_CHECK;
                    end
                    else
                    begin
                        if (fin_reg)
                        begin
                            items_next = '0;
                        end
                        state_next = CTL_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
            half_reg <= HALF_RESET;
            items_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg <= half_next;
            items_reg <= items_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg <= age_next;
        fin_reg <= fin_next;
        out_reg <= out_next;
    end

    rms_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .meas     (s_tdata[LEN_W-1:0]),
        .comp     (s_tdata[2*LEN_W-1:LEN_W]),
        .done     (div_done),
        .quotient (div_q)
    );

    rms_median #(
        .MAX_HALF (MAX_HALF)
    ) u_median (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (div_done),
        .wr_data (div_q),
        .start   (med_start),
        .hi      (med_hi),
        .done    (med_done),
        .result  (med_res)
    );

    `RMS_ASSERT(a_in_out_excl, !(s_tready && m_tvalid), "input taken while result pending")
    `RMS_ASSERT(a_med_when_wait, med_done |-> (state_reg == CTL_MWAIT), "median done out of turn")
    `RMS_ASSERT(a_div_when_div, div_done |-> (state_reg == CTL_DIV), "divider done out of turn")
    `RMS_ASSERT(a_run_end_clear, (m_tvalid && m_tready && m_tlast) |=> (items_reg == '0 && state_reg == CTL_IDLE), "run not closed after last result")

endmodule

// File: design/rms_divider.sv
module rms_divider
    import rms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [LEN_W-1:0]   meas,
    input  logic [LEN_W-1:0]   comp,
    output logic               done,
    output logic [RATIO_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [QCNT_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [LEN_W-1:0]     div_reg, div_next;
    logic [RATIO_W-1:0]   low_reg, low_next;
    logic [RATIO_W-1:0]   q_reg, q_next;
    logic [LEN_W:0]       trial;
    logic                 ovf;

    assign ovf = {{OVF_SH{1'b0}}, meas} >= {comp, {OVF_SH{1'b0}}};
    assign trial = {rem_reg, low_reg[RATIO_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        low_next = low_reg;
        q_next = q_reg;
        if (start)
        begin
            div_next = comp;
            if (ovf)
            begin
                // zero divisor lands here too
                q_next = RATIO_MAX;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next = QCNT_W'(RATIO_W);
                rem_next = LEN_W'(meas >> OVF_SH);
                low_next = {meas[OVF_SH-1:0], {FRAC_BITS{1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = LEN_W'(trial - {1'b0, div_reg});
                q_next = {q_reg[RATIO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LEN_W-1:0];
                q_next = {q_reg[RATIO_W-2:0], 1'b0};
            end
            low_next = {low_reg[RATIO_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        low_reg <= low_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;

endmodule

// File: design/rms_median.sv
module rms_median
    import rms_pkg::*;
#(
    parameter int MAX_HALF = MAX_HALF_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [RATIO_W-1:0]                   wr_data,
    input  logic                                 start,
    input  logic [$clog2(2*MAX_HALF+1)-1:0]      hi,
    output logic                                 done,
    output logic [RATIO_W-1:0]                   result
);

    localparam int DEPTH = 2 * MAX_HALF + 1;
    localparam int AW = $clog2(DEPTH);

    logic [RATIO_W-1:0] mem [DEPTH];
    logic [RATIO_W-1:0] rd_data_reg;
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_age;
    logic [AW:0]        idx_sum;
    logic [AW-1:0]      rd_addr;

    med_state_t         state_reg, state_next;
    logic [AW-1:0]      c_reg, c_next;
    logic [AW-1:0]      j_reg, j_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [RATIO_W-1:0] cand_reg, cand_next;
    logic [RATIO_W-1:0] res_reg, res_next;
    logic               done_reg, done_next;
    logic               less;
    logic [AW-1:0]      cnt_inc;
    logic [AW:0]        target;

    // age counts back from the newest ratio
    assign rd_age = (state_reg == MED_CAND) ? c_reg : j_reg;
    assign idx_sum = {1'b0, wr_ptr_reg} + (AW+1)'(DEPTH - 1) - {1'b0, rd_age};
    assign rd_addr = (idx_sum >= (AW+1)'(DEPTH)) ? AW'(idx_sum - (AW+1)'(DEPTH))
                                                 : idx_sum[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
        end
        else if (wr_en)
        begin
            wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
    end

    // rank of candidate: smaller values, ties broken by age
    assign less = (rd_data_reg < cand_reg) || ((rd_data_reg == cand_reg) && (j_reg < c_reg));
    assign cnt_inc = cnt_reg + AW'(less);
    assign target = ({1'b0, hi_reg} + 1'b1) >> 1;

    always_comb
    begin
        state_next = state_reg;
        c_next = c_reg;
        j_next = j_reg;
        hi_next = hi_reg;
        cnt_next = cnt_reg;
        cand_next = cand_reg;
        res_next = res_reg;
        done_next = 1'b0;
        unique case (state_reg)
            MED_IDLE:
            begin
                if (start)
                begin
                    hi_next = hi;
                    c_next = '0;
                    state_next = MED_CAND;
                end
            end
            MED_CAND:
            begin
                state_next = MED_LOAD;
            end
            MED_LOAD:
            begin
                cand_next = rd_data_reg;
                j_next = '0;
                cnt_next = '0;
                state_next = MED_READ;
            end
            MED_READ:
            begin
                state_next = MED_CMP;
            end
            MED_CMP:
            begin
                cnt_next = cnt_inc;
                if (j_reg == hi_reg)
                begin
                    if ({1'b0, cnt_inc} == target)
                    begin
                        res_next = cand_reg;
                        done_next = 1'b1;
                        state_next = MED_IDLE;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                        state_next = MED_CAND;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = MED_READ;
                end
            end
            default:
            begin
                state_next = MED_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MED_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next;
        j_reg <= j_next;
        hi_reg <= hi_next;
        cnt_reg <= cnt_next;
        cand_reg <= cand_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign result = res_reg;

endmodule
